FILE: sv/bfe_pkg.sv
// Package: shared constants, types and codes for the brace framer with line echo.
`timescale 1ns / 1ps

package bfe_pkg;

  localparam int MSG_SLOTS = 8;
  localparam int SLOT_W    = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 10;
  localparam int FSLOT_W   = 3;
  localparam int CNT_W     = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PROMPT = 8'h3E;

  // What a stepped byte turns into on the output side
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_NL,
    KIND_NL_PROMPT
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   ch;
    logic                done;
    logic [FSLOT_W-1:0]  slot;
    logic [POS_W-1:0]    start;
    logic [POS_W-1:0]    stop;
  } rec_t;

  // Status from the output stage back to the input stage
  typedef struct packed {
    logic free;
  } seq_stat_t;

endpackage

FILE: sv/bfe_ifs.sv
// Interfaces: byte input channel and echo/frame result channel.
`timescale 1ns / 1ps

interface bfe_in_if;
  logic                valid;
  logic                ready;
  logic [7:0]          in_char;
  logic [9:0]          position;

  modport source (output valid, output in_char, output position, input ready);
  modport sink   (input valid, input in_char, input position, output ready);
endinterface

interface bfe_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          out_char;
  logic                frame_done;
  logic [2:0]          frame_slot;
  logic [9:0]          frame_start;
  logic [9:0]          frame_end;
  logic                last;

  modport source (output valid, output out_char, output frame_done, output frame_slot,
                  output frame_start, output frame_end, output last, input ready);
  modport sink   (input valid, input out_char, input frame_done, input frame_slot,
                  input frame_start, input frame_end, input last, output ready);
endinterface

FILE: sv/bfe_framer.sv
// Framer: brace counting, frame capture, slot ring and newline-run state.
`timescale 1ns / 1ps

module bfe_framer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [bfe_pkg::CHAR_W-1:0] ch,
  input  logic [bfe_pkg::POS_W-1:0]  pos,
  output logic                    emit,
  output bfe_pkg::rec_t           rec
);
  import bfe_pkg::*;

  logic               in_object, in_object_next;
  logic [CNT_W-1:0]   open_count, open_count_next;
  logic [CNT_W-1:0]   close_count, close_count_next;
  logic [POS_W-1:0]   start_pos, start_pos_next;
  logic [POS_W-1:0]   end_pos, end_pos_next;
  logic [SLOT_W-1:0]  slot_index, slot_index_next;
  logic               in_newline_run, in_newline_run_next;

  logic               is_nl;
  logic               done;
  logic [SLOT_W+FSLOT_W-1:0] slot_ext;
  logic               prompt;

  always_comb begin
    in_object_next   = in_object;
    open_count_next  = open_count;
    close_count_next = close_count;
    start_pos_next   = start_pos;
    end_pos_next     = end_pos;
    slot_index_next  = slot_index;
    done             = 1'b0;
    slot_ext         = '0;

    if (!in_object) begin
      if (ch == CH_LBRACE) begin
        in_object_next  = 1'b1;
        start_pos_next  = pos;
        open_count_next = CNT_W'(1);
      end
    end else begin
      if (ch == CH_LBRACE && open_count != CNT_MAX) begin
        open_count_next = open_count + CNT_W'(1);
      end
      if (ch == CH_RBRACE) begin
        end_pos_next = pos;
        if (close_count != CNT_MAX) begin
          close_count_next = close_count + CNT_W'(1);
        end
      end
      if (open_count_next <= close_count_next) begin
        done     = 1'b1;
        slot_ext = {{FSLOT_W{1'b0}}, slot_index};
        if (slot_index == SLOT_W'(MSG_SLOTS - 1)) begin
          slot_index_next = '0;
        end else begin
          slot_index_next = slot_index + SLOT_W'(1);
        end
        in_object_next   = 1'b0;
        open_count_next  = '0;
        close_count_next = '0;
        start_pos_next   = '0;
        end_pos_next     = '0;
      end
    end

    is_nl               = (ch == CH_LF) || (ch == CH_CR);
    in_newline_run_next = is_nl;
    emit                = !(is_nl && in_newline_run);
    prompt              = in_object_next && (open_count_next > close_count_next);

    rec.ch    = ch;
    rec.done  = done;
    rec.slot  = slot_ext[FSLOT_W-1:0];
    rec.start = done ? start_pos : '0;
    rec.stop  = done ? pos : '0;
    if (!is_nl) begin
      rec.kind = KIND_DATA;
    end else if (prompt) begin
      rec.kind = KIND_NL_PROMPT;
    end else begin
      rec.kind = KIND_NL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_object      <= 1'b0;
      open_count     <= '0;
      close_count    <= '0;
      start_pos      <= '0;
      end_pos        <= '0;
      slot_index     <= '0;
      in_newline_run <= 1'b0;
    end else if (step) begin
      in_object      <= in_object_next;
      open_count     <= open_count_next;
      close_count    <= close_count_next;
      start_pos      <= start_pos_next;
      end_pos        <= end_pos_next;
      slot_index     <= slot_index_next;
      in_newline_run <= in_newline_run_next;
    end
  end

endmodule

FILE: sv/bfe_seq.sv
// Output stage: result register that plays out one to three words per byte.
`timescale 1ns / 1ps

module bfe_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  bfe_pkg::rec_t      load_rec,
  output bfe_pkg::seq_stat_t stat,
  bfe_out_if.source          tx
);
  import bfe_pkg::*;

  logic        b_valid;
  rec_t        b_rec;
  logic [1:0]  idx;
  logic        cur_last;

  always_comb begin
    tx.frame_done  = 1'b0;
    tx.frame_slot  = '0;
    tx.frame_start = '0;
    tx.frame_end   = '0;
    case (b_rec.kind)
      KIND_DATA: begin
        cur_last       = 1'b1;
        tx.out_char    = b_rec.ch;
        tx.frame_done  = b_rec.done;
        tx.frame_slot  = b_rec.slot;
        tx.frame_start = b_rec.start;
        tx.frame_end   = b_rec.stop;
      end
      KIND_NL: begin
        cur_last    = (idx == 2'd1);
        tx.out_char = (idx == 2'd0) ? CH_LF : CH_CR;
      end
      KIND_NL_PROMPT: begin
        cur_last = (idx == 2'd2);
        case (idx)
          2'd0:    tx.out_char = CH_LF;
          2'd1:    tx.out_char = CH_CR;
          default: tx.out_char = CH_PROMPT;
        endcase
      end
      default: begin
        cur_last    = 1'b1;
        tx.out_char = b_rec.ch;
      end
    endcase
    tx.last   = cur_last;
    tx.valid  = b_valid;
    stat.free = !b_valid || (tx.ready && cur_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      b_valid <= 1'b1;
      idx     <= '0;
    end else if (b_valid && tx.ready) begin
      if (cur_last) begin
        b_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_rec <= load_rec;
    end
  end

endmodule

FILE: sv/brace_framer_with_line_echo_top.sv
// Top level: brace framer with line echo, input register feeding framer and output stage.
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+-------------
//  rx      | in  | in_char[7:0], position[9:0]                          | valid/ready
//  tx      | out | out_char[7:0], frame_done, frame_slot[2:0],          | valid/ready
//          |     | frame_start[9:0], frame_end[9:0], last               |
//
//  One byte per cycle sustained while tx is ready. A data byte gives one word; the
//  first CR/LF of a run gives two words (LF, CR) or three (LF, CR, '>') while an
//  object is open, played out one per cycle from the output register while tx is
//  ready, and holds the input stage until the last one is taken. Later CR/LF bytes
//  of a run give no word. Words pass the input register, then the result register.
//  rst is synchronous, active high, and clears framing state, slot ring and both stages.
//  tx stalls back up through the output register; rx still takes one byte into the
//  input register while a word waits.
`timescale 1ns / 1ps

module brace_framer_with_line_echo_top (
  input  logic      clk,
  input  logic      rst,
  bfe_in_if.sink    rx,
  bfe_out_if.source tx
);
  import bfe_pkg::*;

  // Input register stage
  logic               a_valid;
  logic [CHAR_W-1:0]  a_char;
  logic [POS_W-1:0]   a_pos;
  logic               a_move;

  seq_stat_t          seq_stat;
  rec_t               rec;
  logic               emit;

  assign a_move   = a_valid && seq_stat.free;
  assign rx.ready = !a_valid || seq_stat.free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      a_char <= rx.in_char;
      a_pos  <= rx.position;
    end
  end

  // Framing state steps once per byte as it leaves the input register
  bfe_framer u_framer (
    .clk  (clk),
    .rst  (rst),
    .step (a_move),
    .ch   (a_char),
    .pos  (a_pos),
    .emit (emit),
    .rec  (rec)
  );

  // Suppressed newline-run bytes never reach the output register
  bfe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (a_move && emit),
    .load_rec (rec),
    .stat     (seq_stat),
    .tx       (tx)
  );

endmodule

FILE: sv/bfe_checker.sv
// Checker: port-level properties of the framer output, bound to the top level.
`timescale 1ns / 1ps

module bfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_out_char,
  input logic       tx_frame_done,
  input logic [2:0] tx_frame_slot,
  input logic [9:0] tx_frame_start,
  input logic [9:0] tx_frame_end,
  input logic       tx_last
);
  import bfe_pkg::*;

  // Frame fields read zero unless a frame closes
  a_idle_frame_zero: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_frame_done |->
      tx_frame_slot == '0 && tx_frame_start == '0 && tx_frame_end == '0)
    else $error("frame fields nonzero without frame_done");

  // Only a closing brace completes a frame, and it is a single word
  a_done_on_brace: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_frame_done |-> tx_out_char == CH_RBRACE && tx_last)
    else $error("frame_done on a word other than a final closing brace");

  // LF always opens a newline burst, never ends it
  a_lf_not_last: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_out_char == CH_LF |-> !tx_last)
    else $error("LF word marked last");

  // CR follows a taken LF directly
  a_cr_after_lf: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && tx_out_char == CH_LF |=> tx_valid && tx_out_char == CH_CR)
    else $error("LF not followed by CR");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_char) && $stable(tx_last))
    else $error("output word changed while stalled");

endmodule

bind brace_framer_with_line_echo_top bfe_checker u_bfe_checker (
  .clk            (clk),
  .rst            (rst),
  .tx_valid       (tx.valid),
  .tx_ready       (tx.ready),
  .tx_out_char    (tx.out_char),
  .tx_frame_done  (tx.frame_done),
  .tx_frame_slot  (tx.frame_slot),
  .tx_frame_start (tx.frame_start),
  .tx_frame_end   (tx.frame_end),
  .tx_last        (tx.last)
);

FILE: verif/bfe_echo_frame_checker.sv
// Checker: watches the byte and result channels, predicts echo/frame words, compares them.
`timescale 1ns / 1ps

module bfe_echo_frame_checker (
  input  logic clk,
  input  logic rst,
  bfe_in_if    rx,
  bfe_out_if   tx,
  output int   errors,
  output int   pending
);
  import bfe_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               done;
    logic [FSLOT_W-1:0] slot;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   stop;
    logic               last;
  } echo_word_t;

  echo_word_t due_words[$];

  // framing and echo state
  logic              in_obj;
  logic [CNT_W-1:0]  opens;
  logic [CNT_W-1:0]  closes;
  logic [POS_W-1:0]  obj_start;
  logic [POS_W-1:0]  obj_stop;
  logic [SLOT_W-1:0] slot_idx;
  logic              nl_run;

  function automatic echo_word_t mk_word(logic [CHAR_W-1:0] ch, logic done,
                                         logic [FSLOT_W-1:0] slot, logic [POS_W-1:0] st,
                                         logic [POS_W-1:0] en, logic last);
    echo_word_t w;
    w.ch = ch; w.done = done; w.slot = slot; w.start = st; w.stop = en; w.last = last;
    return w;
  endfunction

  task automatic clear_object();
    in_obj = 1'b0;
    opens = '0;
    closes = '0;
    obj_start = '0;
    obj_stop = '0;
  endtask

  task automatic step_framer(input logic [CHAR_W-1:0] ch, input logic [POS_W-1:0] pos);
    logic               done;
    logic [FSLOT_W-1:0] dslot;
    logic [POS_W-1:0]   dstart;
    logic [POS_W-1:0]   dstop;
    logic               prompt;
    done = 1'b0; dslot = '0; dstart = '0; dstop = '0;
    if (!in_obj) begin
      if (ch == CH_LBRACE) begin
        in_obj = 1'b1;
        obj_start = pos;
        opens = CNT_W'(1);
      end
    end else begin
      if (ch == CH_LBRACE && opens != CNT_MAX) opens++;
      if (ch == CH_RBRACE) begin
        obj_stop = pos;
        if (closes != CNT_MAX) closes++;
      end
      if (opens <= closes) begin
        done = 1'b1;
        dslot = FSLOT_W'(slot_idx);
        dstart = obj_start;
        dstop = obj_stop;
        slot_idx = (slot_idx == SLOT_W'(MSG_SLOTS - 1)) ? '0 : slot_idx + 1'b1;
        clear_object();
      end
    end
    if (ch == CH_LF || ch == CH_CR) begin
      if (!nl_run) begin
        nl_run = 1'b1;
        prompt = in_obj && opens > closes;
        due_words.push_back(mk_word(CH_LF, 1'b0, '0, '0, '0, 1'b0));
        due_words.push_back(mk_word(CH_CR, 1'b0, '0, '0, '0, !prompt));
        if (prompt) due_words.push_back(mk_word(CH_PROMPT, 1'b0, '0, '0, '0, 1'b1));
      end
    end else begin
      nl_run = 1'b0;
      due_words.push_back(mk_word(ch, done, dslot, dstart, dstop, 1'b1));
    end
  endtask

  task automatic note_error(input echo_word_t exp_w, input echo_word_t got_w, input bit stray);
    errors++;
    if (errors <= 10) begin
      if (stray)
        $display("%0t: unexpected word ch=%h done=%b slot=%0d start=%0d end=%0d last=%b",
                 $realtime, got_w.ch, got_w.done, got_w.slot, got_w.start, got_w.stop,
                 got_w.last);
      else
        $display("%0t: mismatch exp ch=%h done=%b slot=%0d start=%0d end=%0d last=%b",
                 $realtime, exp_w.ch, exp_w.done, exp_w.slot, exp_w.start, exp_w.stop,
                 exp_w.last, " | got ch=%h done=%b slot=%0d start=%0d end=%0d last=%b",
                 got_w.ch, got_w.done, got_w.slot, got_w.start, got_w.stop, got_w.last);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    echo_word_t got_w;
    echo_word_t exp_w;
    if (rst) begin
      clear_object();
      slot_idx = '0;
      nl_run = 1'b0;
      due_words.delete();
    end else begin
      // outputs first: a word can never stem from a byte taken on the same edge
      if (tx.valid && tx.ready) begin
        got_w = mk_word(tx.out_char, tx.frame_done, tx.frame_slot, tx.frame_start,
                        tx.frame_end, tx.last);
        if (due_words.size() == 0) begin
          note_error(got_w, got_w, 1'b1);
        end else begin
          exp_w = due_words.pop_front();
          if (got_w.ch !== exp_w.ch || got_w.done !== exp_w.done ||
              got_w.slot !== exp_w.slot || got_w.start !== exp_w.start ||
              got_w.stop !== exp_w.stop || got_w.last !== exp_w.last)
            note_error(exp_w, got_w, 1'b0);
        end
      end
      if (rx.valid && rx.ready) step_framer(rx.in_char, rx.position);
    end
    pending = due_words.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top: clock, reset, byte stimulus, result-side backpressure and verdict.
`timescale 1ns / 1ps

module tb;
  import bfe_pkg::*;

  logic clk;
  logic rst;
  int   fail_cnt;
  int   words_due;

  // stimulus bookkeeping
  int               sent;       // bytes accepted so far
  logic [POS_W-1:0] pos_ctr;    // running buffer index
  bit               calm;       // no idling on either side while set

  bfe_in_if  rx_if ();
  bfe_out_if tx_if ();

  brace_framer_with_line_echo_top dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  bfe_echo_frame_checker chk (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .tx      (tx_if),
    .errors  (fail_cnt),
    .pending (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop; far beyond the slowest legal run (~450 bytes, <=3 words each, 6% stalls).
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: ready drops ~6% of cycles, held high through the calm stretch.
  initial tx_if.ready = 1'b0;
  always @(posedge clk) begin
    if (calm) begin
      tx_if.ready <= 1'b1;
    end else begin
      tx_if.ready <= ($urandom_range(0, 99) >= 6);
    end
  end

  // Offer one word, with random idle cycles ahead of it; returns on the accepting edge.
  // Ready is sampled right after the edge, so it holds its pre-edge value.
  task automatic push_at(input logic [CHAR_W-1:0] ch, input logic [POS_W-1:0] pos);
    while (!calm && $urandom_range(0, 99) < 6) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid    <= 1'b1;
    rx_if.in_char  <= ch;
    rx_if.position <= pos;
    do @(posedge clk); while (!rx_if.ready);
    sent++;
  endtask

  // Mostly a running buffer index, now and then a jump anywhere.
  task automatic push_byte(input logic [CHAR_W-1:0] ch);
    if ($urandom_range(0, 9) == 0) begin
      push_at(ch, POS_W'($urandom));
    end else begin
      push_at(ch, pos_ctr);
    end
    pos_ctr++;
  endtask

  // Ordinary payload byte: anything but braces and line ends.
  function automatic logic [CHAR_W-1:0] plain_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == CH_LBRACE || c == CH_RBRACE || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // 1..3 line-end bytes in any CR/LF mix; at most the first one echoes
  task automatic push_newline_run();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
  endtask

  // One object with nested braces, text and line ends; left open if close_it is clear
  task automatic push_object(input bit close_it);
    int depth;
    int len;
    int r;
    push_byte(CH_LBRACE);
    depth = 1;
    len = $urandom_range(0, 12);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        push_byte(CH_LBRACE);
        depth++;
      end else if (r < 30 && depth > 1) begin
        push_byte(CH_RBRACE);
        depth--;
      end else if (r < 40) begin
        push_newline_run();
      end else begin
        push_byte(plain_byte());
      end
    end
    if (close_it) begin
      while (depth > 0) begin
        push_byte(CH_RBRACE);
        depth--;
      end
    end
  endtask

  initial begin
    int rand_base;
    int r;
    rst            <= 1'b1;
    rx_if.valid    <= 1'b0;
    rx_if.in_char  <= '0;
    rx_if.position <= '0;
    sent = 0;
    pos_ctr = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    push_at(CH_RBRACE, 10'd0);        // closing brace with no object open: echo only
    push_at(8'h00, 10'h3FF);
    push_at(8'hFF, 10'h2AA);
    push_at(CH_LF, 10'h155);          // newline outside an object: LF, CR
    push_at(CH_CR, 10'd6);            // rest of the run is swallowed
    push_at(CH_LF, 10'd7);
    push_at(8'h41, 10'd8);            // ends the run
    push_at(CH_LBRACE, 10'h3FF);      // first brace opens the frame
    push_at(CH_CR, 10'd100);          // newline inside object: LF, CR, prompt
    push_at(CH_LF, 10'd101);
    push_at(CH_LBRACE, 10'h155);      // nested open, counted
    push_at(8'h78, 10'd12);
    push_at(CH_RBRACE, 10'h3FF);
    push_at(CH_RBRACE, 10'd0);        // closes it: slot 0, start 1023, end 0
    push_at(CH_CR, 10'd14);           // frame closed, no prompt
    push_at(CH_LBRACE, 10'd0);
    push_at(CH_RBRACE, 10'h3FF);      // smallest object, slot 1
    push_at(CH_LBRACE, 10'h2AA);
    push_at(CH_LBRACE, 10'h155);
    push_at(CH_LF, 10'd20);
    push_at(CH_RBRACE, 10'd21);
    push_at(CH_RBRACE, 10'd22);       // slot 2
    // walk the slot ring through its wrap
    repeat (7) begin
      push_byte(CH_LBRACE);
      push_byte(CH_RBRACE);
    end

    // --- random: mostly well-formed objects, some noise and broken ones ---
    rand_base = sent;
    while (sent < rand_base + 360) begin
      calm = (sent >= rand_base + 130) && (sent < rand_base + 230);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        push_object(1'b1);
      end else if (r < 75) begin
        push_object(1'b0);
      end else if (r < 85) begin
        push_newline_run();
      end else begin
        push_byte(CHAR_W'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;
    rx_if.valid <= 1'b0;

    // drain: let the checker see the last byte, then wait out every expected word
    repeat (2) @(posedge clk);
    wait (words_due == 0);
    repeat (16) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bfe_pkg.sv
sv/bfe_ifs.sv
sv/bfe_framer.sv
sv/bfe_seq.sv
sv/brace_framer_with_line_echo_top.sv
sv/bfe_checker.sv
verif/bfe_echo_frame_checker.sv
verif/tb.sv
